// File: design/lphm_pkg.sv
package lphm_pkg;

   // Default table size: 2^LG_SLOTS slots.
   localparam int LG_SLOTS_DEFAULT = 12;

   // Widths of the request and response fields.
   localparam int REQ_TYPE_W = 2;
   localparam int KEY_W      = 64;
   localparam int HASH_W     = 32;
   localparam int TARGET_W   = 12;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 12;

   // Stream word widths; the tdata widths are padded to whole bytes.
   localparam int REQ_TDATA_W = 112;
   localparam int REQ_TUSER_W = REQ_TYPE_W;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = STATUS_W;

   // Request kinds.
   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd5;

   // Verdict of the shared step unit on one table entry.
   typedef struct packed {
      logic slot_empty;  // entry holds the empty key
      logic key_match;   // entry holds the key being looked up
      logic stays;       // entry's home lies cyclically in (hole, cur]
   } step_flags_type;

endpackage

// File: design/lphm_step.sv
module lphm_step #(
   parameter int LG_SLOTS = lphm_pkg::LG_SLOTS_DEFAULT
) (
   input  logic [lphm_pkg::KEY_W-1:0] entry_key,
   input  logic [LG_SLOTS-1:0]        entry_home,
   input  logic [lphm_pkg::KEY_W-1:0] lookup_key,
   input  logic [LG_SLOTS-1:0]        hole_slot,
   input  logic [LG_SLOTS-1:0]        cur_slot,
   output lphm_pkg::step_flags_type   flags,
   output logic [LG_SLOTS-1:0]        next_slot
);

   logic home_after_hole;
   logic home_upto_cur;

   // Key compares against the empty key and the key being searched.
   assign flags.slot_empty = (entry_key == '0);
   assign flags.key_match  = (entry_key == lookup_key);

   // An entry stays put when its home lies cyclically in (hole, cur].
   assign home_after_hole = (hole_slot < entry_home);
   assign home_upto_cur   = (entry_home <= cur_slot);

   assign flags.stays = (hole_slot <= cur_slot) ? (home_after_hole && home_upto_cur)
                                                : (home_after_hole || home_upto_cur);

   // Probe advance wraps naturally at the table size.
   assign next_slot = cur_slot + 1'b1;

endmodule

// File: design/linear_probe_hash_map_unit.sv
// Channel   Ports   Direction  Contents
// request   req_*   in         tuser: req_type; tdata: lookup_key, probe_hash, target_slot
// response  rsp_*   out        tuser: status; tdata: result_slot
//
// Insert and query walk the probe chain from the home slot.
// Remove scans the slots after the target until the chain ends.
// Clear sweeps the table to empty, one table write per cycle through the single write port.
// After reset the table is swept to empty with req_tready low.
// One request is in work at a time; a finished word waits in the response register
// while the next request is accepted.
module linear_probe_hash_map_unit #(
   parameter int LG_SLOTS = lphm_pkg::LG_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Bits from 0: lookup_key[63:0], probe_hash[95:64], target_slot[107:96], zero pad.
   input  logic [lphm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Bits from 0: req_type[1:0].
   input  logic [lphm_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Bits from 0: result_slot[11:0], zero pad.
   output logic [lphm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Bits from 0: status[2:0].
   output logic [lphm_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int SLOTS   = 2 ** LG_SLOTS;
   localparam int ENTRY_W = lphm_pkg::KEY_W + LG_SLOTS;
   localparam logic [LG_SLOTS:0] FULL_LIMIT = (LG_SLOTS + 1)'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PROBE,
      ST_RM_HEAD,
      ST_RM_SCAN,
      ST_REPLY
   } state_type;

   // Request fields.
   logic [lphm_pkg::REQ_TYPE_W-1:0] req_type;
   logic [lphm_pkg::KEY_W-1:0]      lookup_key;
   logic [lphm_pkg::HASH_W-1:0]     probe_hash;
   logic [lphm_pkg::TARGET_W-1:0]   target_slot;
   logic [LG_SLOTS+lphm_pkg::TARGET_W-1:0] target_wide;
   logic [LG_SLOTS-1:0]             target_idx;

   // Control and work registers.
   state_type                       state_ff, state_in;
   logic [lphm_pkg::REQ_TYPE_W-1:0] op_ff, op_in;
   logic [lphm_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [LG_SLOTS-1:0]             home_ff, home_in;
   logic [LG_SLOTS-1:0]             pos_ff, pos_in;
   logic [LG_SLOTS-1:0]             hole_ff, hole_in;
   logic [LG_SLOTS-1:0]             sweep_ff, sweep_in;
   logic                            sweep_reply_ff, sweep_reply_in;
   logic [LG_SLOTS:0]               count_ff, count_in;
   logic [lphm_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [LG_SLOTS-1:0]             slot_ff, slot_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lphm_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [lphm_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [LG_SLOTS+lphm_pkg::SLOT_W-1:0] slot_wide;

   // Slot table: key in the low bits, home slot above it.
   logic [ENTRY_W-1:0]              table_ff [SLOTS];
   logic [ENTRY_W-1:0]              rd_entry_ff;
   logic [LG_SLOTS-1:0]             rd_addr;
   logic                            wr_en;
   logic [LG_SLOTS-1:0]             wr_addr;
   logic [ENTRY_W-1:0]              wr_data;

   // Shared step unit.
   lphm_pkg::step_flags_type        flags;
   logic [LG_SLOTS-1:0]             next_slot;

   assign req_type    = req_tuser;
   assign lookup_key  = req_tdata[lphm_pkg::KEY_W-1:0];
   assign probe_hash  = req_tdata[lphm_pkg::KEY_W +: lphm_pkg::HASH_W];
   assign target_slot = req_tdata[lphm_pkg::KEY_W+lphm_pkg::HASH_W +: lphm_pkg::TARGET_W];
   assign target_wide = {{LG_SLOTS{1'b0}}, target_slot};
   assign target_idx  = target_wide[LG_SLOTS-1:0];

   lphm_step #(
      .LG_SLOTS(LG_SLOTS)
   ) u_step (
      .entry_key (rd_entry_ff[lphm_pkg::KEY_W-1:0]),
      .entry_home(rd_entry_ff[ENTRY_W-1:lphm_pkg::KEY_W]),
      .lookup_key(key_ff),
      .hole_slot (hole_ff),
      .cur_slot  (pos_ff),
      .flags     (flags),
      .next_slot (next_slot)
   );

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      rd_entry_ff <= table_ff[rd_addr];
   end

   // Sequencer next-state and datapath control.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      home_in        = home_ff;
      pos_in         = pos_ff;
      hole_in        = hole_ff;
      sweep_in       = sweep_ff;
      sweep_reply_in = sweep_reply_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      req_tready     = 1'b0;
      rd_addr        = pos_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = '0;
      slot_wide      = {{lphm_pkg::SLOT_W{1'b0}}, slot_ff};

      // The response word leaves when the sink takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SWEEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = '0;
            count_in = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               status_in = lphm_pkg::STATUS_DONE;
               slot_in   = '0;
               state_in  = sweep_reply_ff ? ST_REPLY : ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in   = req_type;
               key_in  = lookup_key;
               home_in = probe_hash[LG_SLOTS-1:0];
               if (req_type == lphm_pkg::REQ_CLEAR) begin
                  sweep_in       = '0;
                  sweep_reply_in = 1'b1;
                  state_in       = ST_SWEEP;
               end else if (req_type == lphm_pkg::REQ_REMOVE) begin
                  pos_in   = target_idx;
                  rd_addr  = target_idx;
                  state_in = ST_RM_HEAD;
               end else if (lookup_key == '0) begin
                  status_in = lphm_pkg::STATUS_INVALID;
                  slot_in   = '0;
                  state_in  = ST_REPLY;
               end else begin
                  pos_in   = probe_hash[LG_SLOTS-1:0];
                  rd_addr  = probe_hash[LG_SLOTS-1:0];
                  state_in = ST_PROBE;
               end
            end
         end

         // Walk the chain until the key or an empty slot turns up.
         ST_PROBE: begin
            if (flags.slot_empty) begin
               state_in = ST_REPLY;
               slot_in  = '0;
               if (op_ff == lphm_pkg::REQ_QUERY) begin
                  status_in = lphm_pkg::STATUS_MISS;
               end else if (count_ff >= FULL_LIMIT) begin
                  status_in = lphm_pkg::STATUS_FULL;
               end else begin
                  wr_en     = 1'b1;
                  wr_addr   = pos_ff;
                  wr_data   = {home_ff, key_ff};
                  count_in  = count_ff + 1'b1;
                  status_in = lphm_pkg::STATUS_DONE;
                  slot_in   = pos_ff;
               end
            end else if (flags.key_match) begin
               state_in = ST_REPLY;
               if (op_ff == lphm_pkg::REQ_QUERY) begin
                  status_in = lphm_pkg::STATUS_DONE;
                  slot_in   = pos_ff;
               end else begin
                  status_in = lphm_pkg::STATUS_DUP;
                  slot_in   = '0;
               end
            end else begin
               pos_in  = next_slot;
               rd_addr = next_slot;
            end
         end

         // The target must hold a key before the chain is closed up.
         ST_RM_HEAD: begin
            if (flags.slot_empty) begin
               status_in = lphm_pkg::STATUS_EMPTY;
               slot_in   = '0;
               state_in  = ST_REPLY;
            end else begin
               hole_in  = pos_ff;
               pos_in   = next_slot;
               rd_addr  = next_slot;
               state_in = ST_RM_SCAN;
            end
         end

         // Backward shift. The hole is written empty only when the chain ends,
         // since slots behind the scan are never read again.
         ST_RM_SCAN: begin
            if (flags.slot_empty) begin
               wr_en     = 1'b1;
               wr_addr   = hole_ff;
               wr_data   = '0;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               status_in = lphm_pkg::STATUS_DONE;
               slot_in   = '0;
               state_in  = ST_REPLY;
            end else begin
               if (!flags.stays) begin
                  wr_en   = 1'b1;
                  wr_addr = hole_ff;
                  wr_data = rd_entry_ff;
                  hole_in = pos_ff;
               end
               pos_in  = next_slot;
               rd_addr = next_slot;
            end
         end

         // Hand the result to the response register once it is free.
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot_wide[lphm_pkg::SLOT_W-1:0];
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         sweep_ff       <= '0;
         sweep_reply_ff <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         sweep_reply_ff <= sweep_reply_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      home_ff       <= home_in;
      pos_ff        <= pos_in;
      hole_ff       <= hole_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(lphm_pkg::RSP_TDATA_W - lphm_pkg::SLOT_W){1'b0}}, rsp_slot_ff};

endmodule

// File: design/lphm_checker.sv
module lphm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lphm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [lphm_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   // A stalled response word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // Only a response with done status may report a slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != lphm_pkg::STATUS_DONE) |-> (rsp_tdata == '0))
      else $error("slot reported with a failing status");

   // Status stays within the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= lphm_pkg::STATUS_EMPTY))
      else $error("undefined status code");

   // One request in work at a time: ready drops right after a word is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

endmodule

bind linear_probe_hash_map_unit lphm_checker u_lphm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
